// ----- sv/cia_pkg.sv -----
`default_nettype none

package cia_pkg;

    // Default operand width
    localparam int WORD_BITS_DEF = 32;

    // Operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

endpackage

`default_nettype wire

// ----- sv/checked_integer_alu.sv -----
`default_nettype none

// Checked signed integer ALU: add, subtract, multiply, truncating divide and power.
// Request channel: in_valid/in_ready with op, left, right. Result channel:
// out_valid/out_ready with value and status (0 ok, 1 overflow, 2 divide by zero,
// 3 invalid op or negative exponent). On any error value is 0.
// One request is worked on at a time; in_ready is high only while the sequencer idles.
// All arithmetic runs through one shared (WORD_BITS+1)-bit adder/subtractor:
//   add, subtract, invalid op, zero divisor, zero exponent: settled in the
//   decode state, then loaded into the output register.
//   multiply, divide: one shift-add or restoring step per cycle, plus sign
//   handling.
//   power: repeated multiply for exponent e below WORD_BITS; larger exponents
//   with |base| >= 2 end at once as overflow.
// The result sits in an output register; the next request is accepted as soon
// as the result has moved there, even if the receiver stalls it. A new result
// waits in the sequencer until the output register is free.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties the
// output register.
module checked_integer_alu
    import cia_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  op,
    input  wire logic signed [WORD_BITS-1:0] left,
    input  wire logic signed [WORD_BITS-1:0] right,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [WORD_BITS-1:0]      value,
    output logic [1:0]                       status
);

    localparam int CW = $clog2(WORD_BITS);
    localparam logic [CW-1:0]        CNT_LAST = CW'(WORD_BITS - 1);
    localparam logic [CW-1:0]        CNT_ONE  = CW'(1);
    localparam logic [WORD_BITS-1:0] WORD_VAL = WORD_BITS'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONE_VAL  = WORD_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ABS_A,
        S_ABS_B,
        S_RUN,
        S_CHECK,
        S_FIX,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] hi_reg, hi_next;
    logic [WORD_BITS-1:0] lo_reg, lo_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        exp_reg, exp_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           res_reg, res_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic [1:0]           status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;

    // Shared adder/subtractor
    logic [WORD_BITS:0]   add_a, add_b, add_sum;
    logic                 add_sub;
    logic                 prod_ok;

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + (WORD_BITS+1)'(add_sub);

    // Product {hi, lo} fits the signed range for the result sign
    assign prod_ok = (hi_reg == '0) &&
                     (!lo_reg[WORD_BITS-1] || (neg_reg && lo_reg[WORD_BITS-2:0] == '0));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        add_a          = '0;
        add_b          = '0;
        add_sub        = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    a_next     = left;
                    b_next     = right;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // Sign-extended add/sub; other ops only check special cases here
                add_a   = {a_reg[WORD_BITS-1], a_reg};
                add_b   = {b_reg[WORD_BITS-1], b_reg};
                add_sub = (op_reg == OP_SUB);
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    lo_next    = add_sum[WORD_BITS-1:0];
                    res_next   = (add_sum[WORD_BITS] != add_sum[WORD_BITS-1]) ?
                                 ST_OVERFLOW : ST_OK;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_MUL)
                begin
                    neg_next   = a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
                    state_next = S_ABS_A;
                end
                else if (op_reg == OP_DIV)
                begin
                    neg_next = a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
                    if (b_reg == '0)
                    begin
                        res_next   = ST_DIVZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ABS_A;
                    end
                end
                else if (op_reg == OP_POW)
                begin
                    neg_next = a_reg[WORD_BITS-1] & b_reg[0];
                    if (b_reg[WORD_BITS-1])
                    begin
                        res_next   = ST_INVALID;
                        state_next = S_DONE;
                    end
                    else if (b_reg == '0)
                    begin
                        lo_next    = ONE_VAL;
                        res_next   = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ABS_A;
                    end
                end
                else
                begin
                    res_next   = ST_INVALID;
                    state_next = S_DONE;
                end
            end

            S_ABS_A:
            begin
                // lo = |a|
                add_b      = {1'b0, a_reg};
                add_sub    = 1'b1;
                lo_next    = a_reg[WORD_BITS-1] ? add_sum[WORD_BITS-1:0] : a_reg;
                state_next = S_ABS_B;
            end

            S_ABS_B:
            begin
                hi_next  = '0;
                cnt_next = '0;
                if (op_reg == OP_POW)
                begin
                    // base magnitude becomes the multiplicand, lo the running power
                    b_next = lo_reg;
                    if (lo_reg[WORD_BITS-1:1] == '0)
                    begin
                        state_next = S_FIX;
                    end
                    else if (b_reg >= WORD_VAL)
                    begin
                        res_next   = ST_OVERFLOW;
                        state_next = S_DONE;
                    end
                    else if (b_reg[CW-1:0] == CNT_ONE)
                    begin
                        state_next = S_FIX;
                    end
                    else
                    begin
                        exp_next   = b_reg[CW-1:0] - CNT_ONE;
                        state_next = S_RUN;
                    end
                end
                else
                begin
                    // b = |b|
                    add_b      = {1'b0, b_reg};
                    add_sub    = 1'b1;
                    b_next     = b_reg[WORD_BITS-1] ? add_sum[WORD_BITS-1:0] : b_reg;
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                if (op_reg == OP_DIV)
                begin
                    // Restoring divide step: remainder in hi, quotient shifts into lo
                    add_a   = {hi_reg, lo_reg[WORD_BITS-1]};
                    add_b   = {1'b0, b_reg};
                    add_sub = 1'b1;
                    if (!add_sum[WORD_BITS])
                    begin
                        hi_next = add_sum[WORD_BITS-1:0];
                        lo_next = {lo_reg[WORD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        hi_next = {hi_reg[WORD_BITS-2:0], lo_reg[WORD_BITS-1]};
                        lo_next = {lo_reg[WORD_BITS-2:0], 1'b0};
                    end
                end
                else
                begin
                    // Shift-add multiply step: multiplier in lo, multiplicand in b
                    add_a   = {1'b0, hi_reg};
                    add_b   = lo_reg[0] ? {1'b0, b_reg} : '0;
                    hi_next = add_sum[WORD_BITS:1];
                    lo_next = {add_sum[0], lo_reg[WORD_BITS-1:1]};
                end
                cnt_next = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (op_reg == OP_DIV)
                begin
                    // Only the most negative value over minus one overflows here
                    if (lo_reg[WORD_BITS-1] && !neg_reg)
                    begin
                        res_next   = ST_OVERFLOW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIX;
                    end
                end
                else if (!prod_ok)
                begin
                    res_next   = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_POW && exp_reg != CNT_ONE)
                begin
                    exp_next   = exp_reg - CNT_ONE;
                    hi_next    = '0;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                // Apply result sign
                add_b      = {1'b0, lo_reg};
                add_sub    = 1'b1;
                lo_next    = neg_reg ? add_sum[WORD_BITS-1:0] : lo_reg;
                res_next   = ST_OK;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    value_next     = (res_reg == ST_OK) ? lo_reg : '0;
                    status_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_ADD;
            a_reg         <= '0;
            b_reg         <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            cnt_reg       <= '0;
            exp_reg       <= '0;
            neg_reg       <= 1'b0;
            res_reg       <= ST_OK;
            value_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            cnt_reg       <= cnt_next;
            exp_reg       <= exp_next;
            neg_reg       <= neg_next;
            res_reg       <= res_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
        end
    end

    // One request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in progress");

    // Errors always carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (value == '0))
        else $error("nonzero value with error status");

    // Iterative unit only runs for multiply, divide and power
    a_run_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (op_reg == OP_MUL || op_reg == OP_DIV || op_reg == OP_POW))
        else $error("iteration entered for a single-cycle op");

    // A new result only loads into a free or draining output register
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result left the sequencer while output stalled");

endmodule

`default_nettype wire

// ----- tb/sv/alu_result_checker.sv -----
`default_nettype none

// Watches both channels of the checked ALU, predicts the outcome of every
// accepted request and compares each delivered result with the oldest
// prediction still waiting.
module alu_result_checker
    import cia_pkg::*;
#(
    parameter int W = WORD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [2:0]          op,
    input  wire logic signed [W-1:0] left,
    input  wire logic signed [W-1:0] right,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic signed [W-1:0] value,
    input  wire logic [1:0]          status,
    output int                       fail_count,
    output int                       pending_results
);

    typedef struct packed {
        logic signed [W-1:0] value;
        logic [1:0]          status;
    } alu_outcome_t;

    alu_outcome_t expected_outcomes[$];
    alu_outcome_t oldest;

    // Exact arithmetic in 64 bits, then a range check against the word size.
    function automatic alu_outcome_t predict_outcome(input logic [2:0] code,
                                                     input logic signed [W-1:0] a_in,
                                                     input logic signed [W-1:0] b_in);
        longint          a;
        longint          b;
        longint          exact;
        longint          lo;
        longint          hi;
        longint          k;
        longint unsigned mag;
        longint unsigned acc;
        longint unsigned lim;
        logic            neg;
        alu_outcome_t    r;

        a = a_in;
        b = b_in;
        hi = (longint'(1) << (W - 1)) - 1;
        lo = -hi - 1;
        exact = 0;
        r.status = ST_OK;
        case (code)
            OP_ADD: exact = a + b;
            OP_SUB: exact = a - b;
            OP_MUL: exact = a * b;
            OP_DIV:
            begin
                // SV signed divide truncates toward zero
                if (b == 0)
                    r.status = ST_DIVZERO;
                else
                    exact = a / b;
            end
            OP_POW:
            begin
                if (b < 0)
                    r.status = ST_INVALID;
                else
                begin
                    // magnitude power, bounded by the limit of the final sign
                    neg = (a < 0) && b[0];
                    mag = (a < 0) ? -a : a;
                    lim = neg ? -lo : hi;
                    acc = 1;
                    if (mag <= 1 && b != 0)
                        acc = mag;
                    else
                        for (k = 0; k < b && r.status == ST_OK; k++)
                        begin
                            acc = acc * mag;
                            if (acc > lim)
                                r.status = ST_OVERFLOW;
                        end
                    exact = neg ? -longint'(acc) : longint'(acc);
                end
            end
            default: r.status = ST_INVALID;
        endcase
        if (r.status == ST_OK && (exact < lo || exact > hi))
            r.status = ST_OVERFLOW;
        r.value = (r.status == ST_OK) ? exact[W-1:0] : '0;
        return r;
    endfunction

    // Queue predictions on request accept, compare on result accept.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_outcomes.delete();
            pending_results = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_outcomes.push_back(predict_outcome(op, left, right));
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: value %0d status %0d",
                             $time, value, status);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = expected_outcomes.pop_front();
                    if (value !== oldest.value)
                    begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, oldest.value, value);
                        fail_count = fail_count + 1;
                    end
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, oldest.status, status);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_results = expected_outcomes.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
    import cia_pkg::*;

    localparam int W               = WORD_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 425;
    // slowest request is a power with an exponent near 31 (repeated multiplies)
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 50;

    // opcodes the block does not define
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic signed [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [2:0]          op        = OP_ADD;
    logic signed [W-1:0] left      = '0;
    logic signed [W-1:0] right     = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [W-1:0] value;
    logic [1:0]          status;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int fail_count;
    int pending_results;

    checked_integer_alu #(.WORD_BITS(W)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .left      (left),
        .right     (right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

    alu_result_checker #(.W(W)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .left            (left),
        .right           (right),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value           (value),
        .status          (status),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result-side back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_request(input logic [2:0] code,
                                input logic signed [W-1:0] a,
                                input logic signed [W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        left     <= a;
        right    <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // operand mix: full range, small, extremes, near-overflow for multiply
    function automatic logic signed [W-1:0] rand_operand();
        logic signed [W-1:0] v;
        int                  pick;

        pick = $urandom_range(0, 99);
        if (pick < 30)
            v = $urandom;
        else if (pick < 55)
            v = $urandom_range(0, 200) - 100;
        else if (pick < 70)
        begin
            case ($urandom_range(0, 6))
                0: v = WORD_MIN;
                1: v = WORD_MAX;
                2: v = 0;
                3: v = 1;
                4: v = -1;
                5: v = WORD_MIN + 1;
                default: v = WORD_MAX - 1;
            endcase
        end
        else if (pick < 85)
            v = $urandom_range(0, 131071);
        else
            v = $urandom >> $urandom_range(0, 31);
        if (pick >= 70 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    task automatic send_random_request();
        logic [2:0]          code;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        int                  pick;

        pick = $urandom_range(0, 99);
        if (pick < 20)
            code = OP_ADD;
        else if (pick < 40)
            code = OP_SUB;
        else if (pick < 60)
            code = OP_MUL;
        else if (pick < 80)
            code = OP_DIV;
        else if (pick < 95)
            code = OP_POW;
        else
            code = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        a = rand_operand();
        b = rand_operand();
        // power: mostly small bases and short exponents, which keep it fast
        if (code == OP_POW)
        begin
            if ($urandom_range(0, 99) < 60)
                a = $urandom_range(0, 24) - 12;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                b = $urandom_range(0, 10);
            else if (pick < 85)
                b = $urandom_range(11, 33);
            else if (pick < 92)
                b = $urandom | WORD_MIN;
            else
                b = $urandom >> 1;
        end
        send_request(code, a, b);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: boundaries and corner cases of each operation
        send_request(OP_ADD, WORD_MAX, 1);
        send_request(OP_ADD, WORD_MIN, -1);
        send_request(OP_ADD, WORD_MAX, WORD_MIN);
        send_request(OP_SUB, WORD_MIN, 1);
        send_request(OP_SUB, 0, WORD_MIN);
        send_request(OP_SUB, WORD_MAX, WORD_MAX);
        send_request(OP_MUL, -65536, 32768);
        send_request(OP_MUL, 65536, 32768);
        send_request(OP_MUL, WORD_MIN, -1);
        send_request(OP_MUL, 0, WORD_MIN);
        send_request(OP_DIV, 7, 0);
        send_request(OP_DIV, WORD_MIN, -1);
        send_request(OP_DIV, -7, 2);
        send_request(OP_DIV, WORD_MIN, WORD_MAX);
        send_request(OP_POW, 0, 0);
        send_request(OP_POW, 5, -1);
        send_request(OP_POW, -2, 31);
        send_request(OP_POW, 2, 31);
        send_request(OP_POW, -2, 32);
        send_request(OP_POW, 3, 19);
        send_request(OP_POW, -1, WORD_MAX);
        send_request(OP_POW, WORD_MIN, 1);
        send_request(OP_UNUSED_LO, WORD_MIN, WORD_MAX);
        send_request(OP_UNUSED_LO + 3'd1, WORD_MAX, WORD_MIN);
        send_request(OP_UNUSED_HI, -1, -1);

        // random phases, each ending with a full drain of results
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 62;
                end
                default:
                begin
                    send_idle_pct = 23;
                    recv_stall_pct <= 23;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_request();
            in_valid <= 1'b0;
            while (pending_results != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
